FILE: rtl/assert_macros.svh
// Assertion macros shared by the keypoint decode RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define KDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdd check failed: next-cycle implication");

`endif

FILE: rtl/kdd_pkg.sv
// Shared widths, codes, structs and the sigmoid tables for the keypoint decode.
// No dependencies; imported by every kdd module.
`default_nettype none

package kdd_pkg;

  // Datapath widths
  localparam int VALUE_W     = 24;
  localparam int FRAC_W      = 12;
  localparam int BOX_W       = 16;
  localparam int MAX_ATTRS   = 64;
  localparam int MIN_ATTRS   = 23;
  localparam int ATTR_CNT_W  = $clog2(MAX_ATTRS);
  localparam int NUM_ATTRS_W = 7;
  localparam int CONF_W      = 13;
  localparam int COLOR_W     = 3;
  localparam int CLASS_W     = 4;
  localparam int COORD_W     = 12;
  localparam int FILTER_W    = 2;

  // Rounded coordinate and span widths
  localparam int RND_W  = (VALUE_W - FRAC_W + 1 > COORD_W + 1) ?
                          (VALUE_W - FRAC_W + 1) : (COORD_W + 1);
  localparam int SPAN_W = RND_W + 1;

  // Attribute positions within a box
  localparam int ATTR_LANDMARKS = 8;
  localparam int ATTR_CONF      = 8;
  localparam int ATTR_COLOR_END = 13;
  localparam int ATTR_CLASS     = 13;
  localparam int ATTR_LAST      = 22;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ATTRS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FILTER   = 2'd2;

  localparam logic [NUM_ATTRS_W-1:0] NUM_ATTRS_RST      = 7'd23;
  localparam logic [CONF_W-1:0]      CONF_THRESHOLD_RST = 13'd1843;
  localparam logic [FILTER_W-1:0]    COLOR_FILTER_RST   = 2'd2;

  // Color filter codes; any other code keeps every box
  localparam logic [FILTER_W-1:0] FILTER_DROP_COLOR1 = 2'd0;
  localparam logic [FILTER_W-1:0] FILTER_DROP_COLOR0 = 2'd1;

  // Sigmoid table: 256 entries for step >= 0, 256 for step < 0
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
  localparam int SIG_SHIFT   = 7;
  localparam logic [63:0] EXP_STEP = 64'd4162825045;

  typedef logic [CONF_W-1:0] sig_tab_t [SIG_ENTRIES];

  // Restoring division, used only while the tables are built
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e starts at 1.0 in Q32 and is scaled by e^(-1/32) each step, rounded half up.
  function automatic sig_tab_t sig_build(input logic neg);
    sig_tab_t    tab;
    logic [63:0] e;
    logic [63:0] den;
    e = 64'd1 << 32;
    for (int i = 0; i <= SIG_ENTRIES; i++) begin
      den = (64'd1 << 32) + e;
      if (!neg && i < SIG_ENTRIES) begin
        tab[i] = CONF_W'(div_u64((64'd1 << 44) + (den >> 1), den));
      end
      if (neg && i > 0) begin
        tab[i-1] = CONF_W'(div_u64((e << 12) + (den >> 1), den));
      end
      e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_POS = sig_build(1'b0);
  localparam sig_tab_t SIG_NEG = sig_build(1'b1);

  // Accumulator status seen by the top level
  typedef struct packed {
    logic                  emit;
    logic                  box_end;
    logic [ATTR_CNT_W-1:0] attr_cnt;
  } acc_status_t;

  // Box summary handed to the result formatter
  typedef struct packed {
    logic [BOX_W-1:0]          box_index;
    logic [CONF_W-1:0]         confidence;
    logic [COLOR_W-1:0]        color_id;
    logic [CLASS_W-1:0]        class_id;
    logic signed [VALUE_W-1:0] min_x;
    logic signed [VALUE_W-1:0] max_x;
    logic signed [VALUE_W-1:0] min_y;
    logic signed [VALUE_W-1:0] max_y;
  } box_state_t;

  // One result item
  typedef struct packed {
    logic [BOX_W-1:0]          box_index;
    logic [CONF_W-1:0]         confidence;
    logic [COLOR_W-1:0]        color_id;
    logic [CLASS_W-1:0]        class_id;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [COORD_W-1:0]        box_width;
    logic [COORD_W-1:0]        box_height;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/kdd_sigmoid.sv
// Sigmoid lookup: logit in Q11.12 to probability in Q0.12.
// Depends on kdd_pkg for the two constant tables.
`default_nettype none

module kdd_sigmoid import kdd_pkg::*; (
  input  logic signed [VALUE_W-1:0] value_i,
  output logic [CONF_W-1:0]         prob_o
);

  localparam int STEP_W = VALUE_W - SIG_SHIFT;
  localparam logic signed [STEP_W-1:0] STEP_LO = STEP_W'(-SIG_ENTRIES);
  localparam logic signed [STEP_W-1:0] STEP_HI = STEP_W'(SIG_ENTRIES - 1);

  logic signed [STEP_W-1:0]    step;
  logic signed [SIG_IDX_W:0]   step_sat;

  always_comb begin
    // floor(logit * 32) in 1/32 steps, clamped to the table span
    step = STEP_W'(value_i >>> SIG_SHIFT);
    if (step < STEP_LO) begin
      step_sat = (SIG_IDX_W+1)'(STEP_LO);
    end else if (step > STEP_HI) begin
      step_sat = (SIG_IDX_W+1)'(STEP_HI);
    end else begin
      step_sat = step[SIG_IDX_W:0];
    end
    // negative steps index by |step| - 1, which is the complement
    if (step_sat[SIG_IDX_W]) begin
      prob_o = SIG_NEG[~step_sat[SIG_IDX_W-1:0]];
    end else begin
      prob_o = SIG_POS[step_sat[SIG_IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kdd_accum.sv
// Per-box accumulation: landmark extents, confidence, color and class argmax.
// Depends on kdd_pkg and kdd_sigmoid.
`default_nettype none

module kdd_accum import kdd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic signed [VALUE_W-1:0] attr_i,
  input  logic                      frame_start_i,
  input  logic [NUM_ATTRS_W-1:0]    num_attrs_i,
  input  logic [CONF_W-1:0]         conf_threshold_i,
  input  logic [FILTER_W-1:0]       color_filter_i,
  output acc_status_t               status_o,
  output box_state_t                box_o
);

  logic [ATTR_CNT_W-1:0]     attr_cnt_q, attr_cnt_d, a;
  logic [BOX_W-1:0]          box_cnt_q, box_cnt_d, box;
  logic [CONF_W-1:0]         conf_q, conf_d, sig_prob;
  logic signed [VALUE_W-1:0] color_val_q, color_val_d;
  logic [COLOR_W-1:0]        color_idx_q, color_idx_d;
  logic signed [VALUE_W-1:0] class_val_q, class_val_d;
  logic [CLASS_W-1:0]        class_idx_q, class_idx_d;
  logic signed [VALUE_W-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic signed [VALUE_W-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic signed [VALUE_W-1:0] pend_x_q, pend_x_d;
  logic [NUM_ATTRS_W-1:0]    n;
  logic                      box_end, keep;

  kdd_sigmoid u_sigmoid (
    .value_i (attr_i),
    .prob_o  (sig_prob)
  );

  always_comb begin
    a   = frame_start_i ? '0 : attr_cnt_q;
    box = frame_start_i ? '0 : box_cnt_q;

    conf_d      = conf_q;
    color_val_d = color_val_q;
    color_idx_d = color_idx_q;
    class_val_d = class_val_q;
    class_idx_d = class_idx_q;
    min_x_d     = min_x_q;
    max_x_d     = max_x_q;
    min_y_d     = min_y_q;
    max_y_d     = max_y_q;
    pend_x_d    = pend_x_q;

    if (a < ATTR_CNT_W'(ATTR_LANDMARKS)) begin
      if (!a[0]) begin
        pend_x_d = attr_i;
      end else if (a == ATTR_CNT_W'(1)) begin
        min_x_d = pend_x_q;
        max_x_d = pend_x_q;
        min_y_d = attr_i;
        max_y_d = attr_i;
      end else begin
        if (pend_x_q < min_x_q) min_x_d = pend_x_q;
        if (pend_x_q > max_x_q) max_x_d = pend_x_q;
        if (attr_i < min_y_q)   min_y_d = attr_i;
        if (attr_i > max_y_q)   max_y_d = attr_i;
      end
    end else if (a == ATTR_CNT_W'(ATTR_CONF)) begin
      conf_d      = sig_prob;
      color_val_d = attr_i;
      color_idx_d = '0;
    end else if (a <= ATTR_CNT_W'(ATTR_LAST)) begin
      // first maximum wins: replace only on strictly greater
      if (a <= ATTR_CNT_W'(ATTR_COLOR_END) && attr_i > color_val_q) begin
        color_val_d = attr_i;
        color_idx_d = COLOR_W'(a - ATTR_CNT_W'(ATTR_CONF));
      end
      if (a == ATTR_CNT_W'(ATTR_CLASS)) begin
        class_val_d = attr_i;
        class_idx_d = '0;
      end else if (a > ATTR_CNT_W'(ATTR_CLASS) && attr_i > class_val_q) begin
        class_val_d = attr_i;
        class_idx_d = CLASS_W'(a - ATTR_CNT_W'(ATTR_CLASS));
      end
    end

    if (num_attrs_i < NUM_ATTRS_W'(MIN_ATTRS)) begin
      n = NUM_ATTRS_W'(MIN_ATTRS);
    end else if (num_attrs_i > NUM_ATTRS_W'(MAX_ATTRS)) begin
      n = NUM_ATTRS_W'(MAX_ATTRS);
    end else begin
      n = num_attrs_i;
    end
    box_end = (NUM_ATTRS_W'(a) + NUM_ATTRS_W'(1)) >= n;
    if (box_end) begin
      attr_cnt_d = '0;
      box_cnt_d  = box + BOX_W'(1);
    end else begin
      attr_cnt_d = a + ATTR_CNT_W'(1);
      box_cnt_d  = box;
    end

    keep = conf_q >= conf_threshold_i;
    if (color_filter_i == FILTER_DROP_COLOR1 && color_idx_q == COLOR_W'(1)) keep = 1'b0;
    if (color_filter_i == FILTER_DROP_COLOR0 && color_idx_q == '0)          keep = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_cnt_q  <= '0;
      box_cnt_q   <= '0;
      conf_q      <= '0;
      color_val_q <= '0;
      color_idx_q <= '0;
      class_val_q <= '0;
      class_idx_q <= '0;
      min_x_q     <= '0;
      max_x_q     <= '0;
      min_y_q     <= '0;
      max_y_q     <= '0;
      pend_x_q    <= '0;
    end else if (advance_i) begin
      attr_cnt_q  <= attr_cnt_d;
      box_cnt_q   <= box_cnt_d;
      conf_q      <= conf_d;
      color_val_q <= color_val_d;
      color_idx_q <= color_idx_d;
      class_val_q <= class_val_d;
      class_idx_q <= class_idx_d;
      min_x_q     <= min_x_d;
      max_x_q     <= max_x_d;
      min_y_q     <= min_y_d;
      max_y_q     <= max_y_d;
      pend_x_q    <= pend_x_d;
    end
  end

  assign status_o.emit     = (a == ATTR_CNT_W'(ATTR_LAST)) && keep;
  assign status_o.box_end  = box_end;
  assign status_o.attr_cnt = attr_cnt_q;

  // last attribute leaves extents, confidence and color alone; class may move
  assign box_o.box_index  = box;
  assign box_o.confidence = conf_q;
  assign box_o.color_id   = color_idx_q;
  assign box_o.class_id   = class_idx_d;
  assign box_o.min_x      = min_x_q;
  assign box_o.max_x      = max_x_q;
  assign box_o.min_y      = min_y_q;
  assign box_o.max_y      = max_y_q;

endmodule

`default_nettype wire

FILE: rtl/kdd_format.sv
// Result formatting: round landmark extents to integers and saturate.
// Depends on kdd_pkg for the box and result structs.
`default_nettype none

module kdd_format import kdd_pkg::*; (
  input  box_state_t box_i,
  output result_t    result_o
);

  localparam logic signed [RND_W-1:0]  C_MAX = RND_W'(2**(COORD_W-1) - 1);
  localparam logic signed [RND_W-1:0]  C_MIN = -C_MAX - RND_W'(1);
  localparam logic signed [SPAN_W-1:0] S_MAX = SPAN_W'(2**COORD_W - 1);

  // round to nearest, ties to even
  function automatic logic signed [RND_W-1:0] round_even(
    input logic signed [VALUE_W-1:0] v
  );
    logic signed [RND_W-1:0] q;
    logic                    up;
    q  = RND_W'(v >>> FRAC_W);
    up = v[FRAC_W-1] && ((|v[FRAC_W-2:0]) || v[FRAC_W]);
    return q + RND_W'(up);
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] c;
    c = v;
    if (v < C_MIN) c = C_MIN;
    if (v > C_MAX) c = C_MAX;
    return c[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] sat_span(
    input logic signed [RND_W-1:0] hi,
    input logic signed [RND_W-1:0] lo
  );
    logic signed [SPAN_W-1:0] d;
    d = SPAN_W'(hi) - SPAN_W'(lo);
    if (d < 0)     d = '0;
    if (d > S_MAX) d = S_MAX;
    return d[COORD_W-1:0];
  endfunction

  logic signed [RND_W-1:0] rx0, rx1, ry0, ry1;

  always_comb begin
    rx0 = round_even(box_i.min_x);
    rx1 = round_even(box_i.max_x);
    ry0 = round_even(box_i.min_y);
    ry1 = round_even(box_i.max_y);

    result_o.box_index  = box_i.box_index;
    result_o.confidence = box_i.confidence;
    result_o.color_id   = box_i.color_id;
    result_o.class_id   = box_i.class_id;
    result_o.box_x      = sat_coord(rx0);
    result_o.box_y      = sat_coord(ry0);
    result_o.box_width  = sat_span(rx1, rx0);
    result_o.box_height = sat_span(ry1, ry0);
  end

endmodule

`default_nettype wire

FILE: rtl/keypoint_detection_decode_top.sv
// Top level of the keypoint detection decode: channels, config registers, result register.
// Depends on kdd_pkg, kdd_accum, kdd_format and assert_macros.svh.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_ready_o  attr_value_i, frame_start_i
//   out       source     out_valid_o/out_ready_i box_index_o .. box_height_o
//   cfg       sink       cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the input does not stall; an item is registered, then accumulated
// as it advances, which also loads its result (if any) into the result register that drives out_valid_o.
// The sigmoid table read plus the argmax compare set the path into the state.
// Reset (rst_ni low, asynchronous) clears counters, box state, valid flags, and
// loads num_attrs 23, conf_threshold 1843, color_filter 2.
// The input side stalls only when the last attribute of a kept box waits while
// the result register still holds an item not taken.
`default_nettype none
`include "assert_macros.svh"

module keypoint_detection_decode_top import kdd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] attr_value_i,
  input  logic                      frame_start_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [BOX_W-1:0]          box_index_o,
  output logic [CONF_W-1:0]         confidence_o,
  output logic [COLOR_W-1:0]        color_id_o,
  output logic [CLASS_W-1:0]        class_id_o,
  output logic signed [COORD_W-1:0] box_x_o,
  output logic signed [COORD_W-1:0] box_y_o,
  output logic [COORD_W-1:0]        box_width_o,
  output logic [COORD_W-1:0]        box_height_o
);

  // Configuration registers
  logic [NUM_ATTRS_W-1:0] num_attrs_q;
  logic [CONF_W-1:0]      conf_threshold_q;
  logic [FILTER_W-1:0]    color_filter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_attrs_q      <= NUM_ATTRS_RST;
      conf_threshold_q <= CONF_THRESHOLD_RST;
      color_filter_q   <= COLOR_FILTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_ATTRS:      num_attrs_q      <= cfg_data_i[NUM_ATTRS_W-1:0];
        CFG_CONF_THRESHOLD: conf_threshold_q <= cfg_data_i[CONF_W-1:0];
        CFG_COLOR_FILTER:   color_filter_q   <= cfg_data_i[FILTER_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Input register: holds one item until the accumulator takes it
  logic                      in_valid_q;
  logic signed [VALUE_W-1:0] attr_q;
  logic                      frame_start_q;
  logic                      out_valid_q;
  result_t                   result_q;
  acc_status_t               status;
  box_state_t                box_state;
  result_t                   result_d;
  logic                      advance;

  // Advance the held item unless it emits into an occupied result register
  assign advance    = in_valid_q && (!status.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      attr_q        <= attr_value_i;
      frame_start_q <= frame_start_i;
    end
  end

  kdd_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .attr_i           (attr_q),
    .frame_start_i    (frame_start_q),
    .num_attrs_i      (num_attrs_q),
    .conf_threshold_i (conf_threshold_q),
    .color_filter_i   (color_filter_q),
    .status_o         (status),
    .box_o            (box_state)
  );

  kdd_format u_format (
    .box_i    (box_state),
    .result_o (result_d)
  );

  // Result register: load on an emitting advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && status.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && status.emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign box_index_o  = result_q.box_index;
  assign confidence_o = result_q.confidence;
  assign color_id_o   = result_q.color_id;
  assign class_id_o   = result_q.class_id;
  assign box_x_o      = result_q.box_x;
  assign box_y_o      = result_q.box_y;
  assign box_width_o  = result_q.box_width;
  assign box_height_o = result_q.box_height;

  // Input stalls only behind a pending result
  `KDD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, in_valid_q && out_valid_q && status.emit)
  // A finished box restarts the attribute count
  `KDD_ASSERT_NXT(a_box_wrap, clk_i, rst_ni, advance && status.box_end, status.attr_cnt == '0)
  // An emitting advance always shows a result next cycle
  `KDD_ASSERT_NXT(a_emit_shows, clk_i, rst_ni, advance && status.emit, out_valid_o)
  // Shown results passed the confidence threshold
  `KDD_ASSERT_IMP(a_conf_kept, clk_i, rst_ni, out_valid_o, confidence_o >= conf_threshold_q)

endmodule

`default_nettype wire

FILE: tb/tb_keypoint_detection_decode_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for keypoint_detection_decode_top: directed boxes, then random frames.
// Depends on kdd_pkg and the RTL; it holds its own decoder model and result queue.

module tb_keypoint_detection_decode_top;
  import kdd_pkg::*;

  localparam int RANDOM_ATTRS  = 220;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 40;

  // Box layout and Q11.12 extremes
  localparam int LANDMARK_ATTRS = 8;
  localparam int CONF_ATTR      = 8;
  localparam int COLOR_LAST     = 13;
  localparam int CLASS_FIRST    = 13;
  localparam int LAST_ATTR      = 22;
  localparam int BOX_ATTRS_MIN  = 23;
  localparam int BOX_ATTRS_MAX  = 64;
  localparam int VALUE_MAX      = 8388607;
  localparam int VALUE_MIN      = -8388608;
  localparam int ONE            = 4096;

  // Filter codes that keep every box
  localparam logic [FILTER_W-1:0] FILTER_KEEP_ALL = 2'd2;
  localparam logic [FILTER_W-1:0] FILTER_KEEP_ALT = 2'd3;

  // e^(-1/32) in Q32
  localparam logic [63:0] EXP_DECAY = 64'd4162825045;

  typedef struct packed {
    logic [15:0] box_index;
    logic [12:0] confidence;
    logic [2:0]  color_id;
    logic [3:0]  class_id;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_width;
    logic [11:0] box_height;
  } box_report_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic [VALUE_W-1:0]    attr_value  = '0;
  logic                  frame_start = 1'b0;
  logic                  out_ready   = 1'b0;

  wire                  in_ready_o;
  wire                  out_valid_o;
  wire [BOX_W-1:0]      box_index_o;
  wire [CONF_W-1:0]     confidence_o;
  wire [COLOR_W-1:0]    color_id_o;
  wire [CLASS_W-1:0]    class_id_o;
  wire [COORD_W-1:0]    box_x_o;
  wire [COORD_W-1:0]    box_y_o;
  wire [COORD_W-1:0]    box_width_o;
  wire [COORD_W-1:0]    box_height_o;

  keypoint_detection_decode_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .attr_value_i (attr_value),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .box_index_o  (box_index_o),
    .confidence_o (confidence_o),
    .color_id_o   (color_id_o),
    .class_id_o   (class_id_o),
    .box_x_o      (box_x_o),
    .box_y_o      (box_y_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: its own copy of the registers and the per-box state.
  // ---------------------------------------------------------------------------
  logic [6:0]  cfg_num_attrs;
  logic [12:0] cfg_threshold;
  logic [1:0]  cfg_filter;

  int          attr_pos;
  logic [15:0] box_num;
  logic [12:0] conf_q;
  int          color_best, color_idx;
  int          class_best, class_idx;
  int          lm_min_x, lm_max_x, lm_min_y, lm_max_y, lm_pend_x;

  // Q0.12 sigmoid per logit step; index is step + 256
  logic [12:0] sigmoid_lut [0:511];

  box_report_t kept_boxes [$];   // results still owed by the block
  int attrs_sent;
  int mismatches;
  int cycles;

  // Sender and receiver pacing
  bit tx_calm;
  bit rx_calm;
  int rx_hold;
  int rx_wait;

  // Attribute values of the box being built, indexed by position
  int box_vals [0:63];

  function automatic void build_sigmoid_lut();
    logic [63:0] e;
    logic [63:0] den;
    e = 64'd1 << 32;
    for (int k = 0; k <= 256; k++) begin
      den = (64'd1 << 32) + e;
      if (k < 256) sigmoid_lut[256 + k] = 13'(((64'd1 << 44) + den / 2) / den);
      if (k > 0) sigmoid_lut[256 - k] = 13'(((e << 12) + den / 2) / den);
      e = (e * EXP_DECAY + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic void reset_decoder();
    cfg_num_attrs = 7'd23;
    cfg_threshold = 13'd1843;
    cfg_filter    = FILTER_KEEP_ALL;
    attr_pos      = 0;
    box_num       = '0;
    conf_q        = '0;
    color_best    = 0;
    color_idx     = 0;
    class_best    = 0;
    class_idx     = 0;
    lm_min_x      = 0;
    lm_max_x      = 0;
    lm_min_y      = 0;
    lm_max_y      = 0;
    lm_pend_x     = 0;
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Q11.12 to integer, ties to even
  function automatic int round_half_even(input int v);
    int q;
    int r;
    q = v >>> 12;
    r = v & 4095;
    if (r > 2048 || (r == 2048 && q[0])) q++;
    return q;
  endfunction

  function automatic int box_len();
    return clamp(int'(cfg_num_attrs), BOX_ATTRS_MIN, BOX_ATTRS_MAX);
  endfunction

  // Advance the model by one attribute; return 1 when a box report is due.
  function automatic bit decode_attr(input int v, input bit fs, output box_report_t r);
    int n;
    int a;
    int step;
    int rx0, rx1, ry0, ry1;
    bit keep;
    r = '0;
    keep = 1'b0;
    n = box_len();
    if (fs) begin
      attr_pos = 0;
      box_num = '0;
    end
    a = attr_pos;
    if (a < LANDMARK_ATTRS) begin
      if (a % 2 == 0) begin
        lm_pend_x = v;
      end else if (a == 1) begin
        lm_min_x = lm_pend_x;
        lm_max_x = lm_pend_x;
        lm_min_y = v;
        lm_max_y = v;
      end else begin
        if (lm_pend_x < lm_min_x) lm_min_x = lm_pend_x;
        if (lm_pend_x > lm_max_x) lm_max_x = lm_pend_x;
        if (v < lm_min_y) lm_min_y = v;
        if (v > lm_max_y) lm_max_y = v;
      end
    end else if (a == CONF_ATTR) begin
      step = clamp(v >>> 7, -256, 255);
      conf_q = sigmoid_lut[step + 256];
      color_best = v;
      color_idx = 0;
    end else if (a <= LAST_ATTR) begin
      if (a <= COLOR_LAST && v > color_best) begin
        color_best = v;
        color_idx = a - CONF_ATTR;
      end
      // attribute 13 opens the class range while it still counts for color
      if (a == CLASS_FIRST) begin
        class_best = v;
        class_idx = 0;
      end else if (a > CLASS_FIRST && v > class_best) begin
        class_best = v;
        class_idx = a - CLASS_FIRST;
      end
      if (a == LAST_ATTR) begin
        keep = conf_q >= cfg_threshold;
        if (cfg_filter == FILTER_DROP_COLOR1 && color_idx == 1) keep = 1'b0;
        if (cfg_filter == FILTER_DROP_COLOR0 && color_idx == 0) keep = 1'b0;
        if (keep) begin
          rx0 = round_half_even(lm_min_x);
          rx1 = round_half_even(lm_max_x);
          ry0 = round_half_even(lm_min_y);
          ry1 = round_half_even(lm_max_y);
          r.box_index  = box_num;
          r.confidence = conf_q;
          r.color_id   = 3'(color_idx);
          r.class_id   = 4'(class_idx);
          r.box_x      = 12'(clamp(rx0, -2048, 2047));
          r.box_y      = 12'(clamp(ry0, -2048, 2047));
          r.box_width  = 12'(clamp(rx1 - rx0, 0, 4095));
          r.box_height = 12'(clamp(ry1 - ry0, 0, 4095));
        end
      end
    end
    if (a + 1 >= n) begin
      attr_pos = 0;
      box_num++;
    end else begin
      attr_pos = a + 1;
    end
    return keep;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; hold it until accepted, then predict.
  task automatic send_attr(input int v, input bit fs);
    int gap;
    box_report_t res;
    gap = tx_calm ? 0 : $urandom_range(10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    attr_value  <= v[VALUE_W-1:0];
    frame_start <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    attrs_sent++;
    // the block sees only the low VALUE_W bits, taken as signed
    if (decode_attr(int'($signed(v[VALUE_W-1:0])), fs, res)) begin
      kept_boxes = {kept_boxes, res};
    end
  endtask

  // Send box_vals[first..last]; frame start goes on the first one sent.
  task automatic send_box(input int first, input int last, input bit fs);
    for (int p = first; p <= last; p++) send_attr(box_vals[p], fs && p == first);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (kept_boxes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NUM_ATTRS:      cfg_num_attrs = data[6:0];
      CFG_CONF_THRESHOLD: cfg_threshold = data[12:0];
      CFG_COLOR_FILTER:   cfg_filter    = data[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input int na, input int thr, input logic [1:0] flt);
    drain_results();
    write_reg(CFG_NUM_ATTRS, CFG_DATA_W'(na));
    write_reg(CFG_CONF_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_COLOR_FILTER, CFG_DATA_W'(flt));
  endtask

  function automatic int full_value();
    int w;
    w = $urandom();
    return w >>> 8;
  endfunction

  // Random attribute shaped by its position in the box
  function automatic int gen_attr(input int pos);
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return full_value();
    if (pos < LANDMARK_ATTRS) begin
      if (pick < 20) return (int'($urandom_range(4000)) - 2000) * ONE + 2048;
      if (pick < 25) return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      return int'($urandom_range(2000 * ONE)) - 1000 * ONE;
    end
    if (pos == CONF_ATTR) begin
      if (pick < 25) return (int'($urandom_range(511)) - 256) * 128;
      return int'($urandom_range(20 * ONE)) - 6 * ONE;
    end
    if (pos <= LAST_ATTR) begin
      if (pick < 50) return (int'($urandom_range(6)) - 3) * ONE;
      return int'($urandom_range(16 * ONE)) - 8 * ONE;
    end
    return full_value();
  endfunction

  function automatic void fill_random_box();
    for (int p = 0; p < 64; p++) box_vals[p] = gen_attr(p);
  endfunction

  // Random landmarks and tail; color and class winners placed by hand
  function automatic void make_box(input int logit, input int color, input int cls);
    fill_random_box();
    box_vals[CONF_ATTR] = logit;
    for (int p = CONF_ATTR + 1; p <= COLOR_LAST; p++) box_vals[p] = logit - ONE;
    if (color > 0) box_vals[CONF_ATTR + color] = logit + ONE;
    for (int p = CLASS_FIRST + 1; p <= LAST_ATTR; p++) box_vals[p] = box_vals[CLASS_FIRST] - ONE;
    if (cls > 0) box_vals[CLASS_FIRST + cls] = box_vals[CLASS_FIRST] + ONE;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random ready stalls, long holds on request, field checks
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic compare_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : result_side
    box_report_t want;
    if (out_valid_o && out_ready) begin
      if (kept_boxes.size() == 0) begin
        report_mismatch("result with none owed, box_index", int'(box_index_o), -1);
      end else begin
        want = kept_boxes.pop_front();
        compare_field("box_index", int'(box_index_o), int'(want.box_index));
        compare_field("confidence", int'(confidence_o), int'(want.confidence));
        compare_field("color_id", int'(color_id_o), int'(want.color_id));
        compare_field("class_id", int'(class_id_o), int'(want.class_id));
        compare_field("box_x", int'($signed(box_x_o)), int'($signed(want.box_x)));
        compare_field("box_y", int'($signed(box_y_o)), int'($signed(want.box_y)));
        compare_field("box_width", int'(box_width_o), int'(want.box_width));
        compare_field("box_height", int'(box_height_o), int'(want.box_height));
      end
      rx_wait = rx_calm ? 0 : $urandom_range(10);
    end
    // a requested hold replaces the current stall and is counted down here
    if (rx_hold > 0) begin
      rx_wait = rx_hold;
      rx_hold = 0;
    end
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers, value extremes, clamped logits, argmax ties.
  task automatic test_reset_extremes();
    for (int p = 0; p < 64; p++) box_vals[p] = 0;
    box_vals[0] = VALUE_MAX;
    box_vals[1] = VALUE_MAX;
    box_vals[2] = VALUE_MIN;
    box_vals[3] = VALUE_MIN;
    // every color and class candidate equal: earliest index wins
    for (int p = CONF_ATTR; p <= LAST_ATTR; p++) box_vals[p] = VALUE_MAX;
    send_box(0, box_len() - 1, 1'b1);
    // most negative logit: drop on confidence
    make_box(VALUE_MIN, 5, 9);
    send_box(0, box_len() - 1, 1'b0);
    // logit zero sits just above the reset threshold
    make_box(0, 1, 4);
    send_box(0, box_len() - 1, 1'b0);
    // shared attribute 13 wins color while it also opens class
    make_box(2 * ONE, 5, 0);
    send_box(0, box_len() - 1, 1'b0);
  endtask

  // Half-way coordinates round to even; ties at the top saturate.
  task automatic test_rounding_ties();
    make_box(6 * ONE, 0, 3);
    box_vals[0] = 2048;             // 0.5
    box_vals[1] = 10240;            // 2.5
    box_vals[2] = 6144;             // 1.5
    box_vals[3] = 14336;            // 3.5
    box_vals[4] = -2048;            // -0.5
    box_vals[5] = 2049;
    box_vals[6] = -6144;            // -1.5
    box_vals[7] = -2047;
    send_box(0, box_len() - 1, 1'b1);
    make_box(6 * ONE, 2, 7);
    box_vals[0] = 2047 * ONE + 2048;   // rounds to 2048, saturates
    box_vals[1] = -2047 * ONE - 2048;  // rounds to -2048
    box_vals[2] = -2045 * ONE - 2048;
    box_vals[3] = 2046 * ONE + 2048;
    for (int p = 4; p < LANDMARK_ATTRS; p++) box_vals[p] = box_vals[p % 2];
    send_box(0, box_len() - 1, 1'b0);
  endtask

  // Confidence exactly at the threshold, one step under, and the threshold ends.
  task automatic test_conf_threshold();
    int k;
    for (int i = 0; i < 3; i++) begin
      k = int'($urandom_range(300)) - 200;
      set_config(23, int'(sigmoid_lut[k + 256]), FILTER_KEEP_ALL);
      make_box(k * 128 + int'($urandom_range(127)), $urandom_range(5), $urandom_range(9));
      send_box(0, box_len() - 1, 1'b0);
      make_box((k - 1) * 128, $urandom_range(5), $urandom_range(9));
      send_box(0, box_len() - 1, 1'b0);
    end
    set_config(23, 0, FILTER_KEEP_ALL);
    make_box(VALUE_MIN, 0, 0);
    send_box(0, box_len() - 1, 1'b0);
    set_config(23, 4096, FILTER_KEEP_ALL);
    make_box(VALUE_MAX, 0, 0);
    send_box(0, box_len() - 1, 1'b0);
    set_config(23, 8191, FILTER_KEEP_ALL);
    make_box(VALUE_MAX, 3, 2);
    send_box(0, box_len() - 1, 1'b0);
  endtask

  // Each filter code against boxes of color 0 and color 1.
  task automatic test_color_filter();
    logic [1:0] codes [4];
    codes[0] = FILTER_DROP_COLOR1;
    codes[1] = FILTER_DROP_COLOR0;
    codes[2] = FILTER_KEEP_ALL;
    codes[3] = FILTER_KEEP_ALT;
    for (int f = 0; f < 4; f++) begin
      set_config(23, 1843, codes[f]);
      make_box(4 * ONE, 0, $urandom_range(9));
      send_box(0, box_len() - 1, 1'b0);
      make_box(4 * ONE, 1, $urandom_range(9));
      send_box(0, box_len() - 1, 1'b0);
    end
  endtask

  // Box length clamping at both ends, and lowering it in the middle of a box.
  task automatic test_box_length();
    int lens [6];
    lens = '{0, 10, 24, 64, 100, 127};
    foreach (lens[i]) begin
      set_config(lens[i], 0, FILTER_KEEP_ALL);
      make_box(3 * ONE, $urandom_range(5), $urandom_range(9));
      send_box(0, box_len() - 1, 1'b1);
    end
    set_config(64, 0, FILTER_KEEP_ALL);
    make_box(3 * ONE, 2, 6);
    send_box(0, 39, 1'b0);
    // the next item sits past the new end and closes the box
    set_config(30, 0, FILTER_KEEP_ALL);
    send_attr(full_value(), 1'b0);
    make_box(3 * ONE, 4, 8);
    send_box(0, box_len() - 1, 1'b0);
    set_config(23, 1843, FILTER_KEEP_ALL);
  endtask

  // Frame start abandons a partial box and restarts the box count.
  task automatic test_frame_restart();
    make_box(5 * ONE, 1, 1);
    send_box(0, 14, 1'b1);
    make_box(5 * ONE, 2, 5);
    send_box(0, box_len() - 1, 1'b1);
    make_box(5 * ONE, 3, 6);
    send_box(0, box_len() - 1, 1'b0);
    // cut just before the last attribute
    make_box(5 * ONE, 4, 7);
    send_box(0, LAST_ATTR - 1, 1'b0);
    for (int b = 0; b < 3; b++) begin
      make_box(5 * ONE, b, 9 - b);
      send_box(0, box_len() - 1, b == 0);
    end
  endtask

  // Long receiver hold with a steady sender fills the block and stalls its input.
  task automatic test_backpressure();
    set_config(23, 0, FILTER_KEEP_ALL);
    tx_calm = 1'b1;
    rx_hold = LONG_HOLD;
    for (int b = 0; b < 5; b++) begin
      fill_random_box();
      send_box(0, box_len() - 1, b == 0);
    end
    // pause the sender until every result is out
    drain_results();
    tx_calm = 1'b0;
  endtask

  // Random register settings and frames; a few boxes are cut short.
  task automatic test_random_stream();
    int goal;
    int nboxes;
    int len;
    int cut;
    int pick;
    int na;
    int thr;
    bit restart;
    goal = attrs_sent + RANDOM_ATTRS;
    restart = 1'b1;
    while (attrs_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) na = $urandom_range(23, 28);
      else if (pick < 80) na = $urandom_range(29, 64);
      else if (pick < 90) na = $urandom_range(22);
      else na = $urandom_range(65, 127);
      pick = $urandom_range(99);
      if (pick < 60) thr = $urandom_range(3000);
      else if (pick < 70) thr = 0;
      else if (pick < 80) thr = 4096;
      else if (pick < 90) thr = $urandom_range(4097, 8191);
      else thr = $urandom_range(3000, 4095);
      set_config(na, thr, 2'($urandom_range(3)));
      tx_calm = ($urandom_range(4) == 0);
      rx_calm = ($urandom_range(4) == 0);
      nboxes = $urandom_range(2, 6);
      len = box_len();
      for (int b = 0; b < nboxes; b++) begin
        fill_random_box();
        restart = restart || attr_pos != 0 || $urandom_range(3) == 0;
        if ($urandom_range(19) == 0) begin
          cut = $urandom_range(1, len - 1);
          send_box(0, cut - 1, restart);
          restart = 1'b1;
        end else begin
          send_box(0, len - 1, restart);
          restart = 1'b0;
        end
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    build_sigmoid_lut();
    reset_decoder();
    attrs_sent = 0;
    mismatches = 0;
    cycles = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold = 0;
    rx_wait = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_extremes();
    test_rounding_ties();
    test_conf_threshold();
    test_color_filter();
    test_box_length();
    test_frame_restart();
    test_backpressure();
    test_random_stream();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
